// File: rtl/slmc_pkg.sv
// ----------------------------------------------------------------------------
// slmc_pkg
// Shared constants, codes and control types of the sorted list merge block.
// ----------------------------------------------------------------------------
package slmc_pkg;

    // list storage
    localparam int unsigned LIST_DEPTH = 1024;
    localparam int unsigned ID_WIDTH   = 16;
    localparam int unsigned PTR_W      = $clog2(LIST_DEPTH);
    localparam int unsigned CNT_W      = PTR_W + 1;

    // item fields
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned VALUE_W = 16;
    localparam int unsigned MEMB_W  = 2;

    localparam logic [CNT_W-1:0] LIST_FULL = CNT_W'(LIST_DEPTH);

    // request kinds
    localparam logic [KIND_W-1:0] KIND_LOAD_FIRST  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_SECOND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMIT        = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR       = 2'd3;

    // membership tags
    localparam logic [MEMB_W-1:0] MEMB_FIRST  = 2'd0;
    localparam logic [MEMB_W-1:0] MEMB_SECOND = 2'd1;
    localparam logic [MEMB_W-1:0] MEMB_BOTH   = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load_first;
        logic load_second;
        logic clear;
        logic emit;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_busy;
    } t_dp_status;

endpackage

// File: rtl/slmc_in_if.sv
// ----------------------------------------------------------------------------
// slmc_in_if
// Request channel: load, emit and clear items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface slmc_in_if;

    logic                              valid;
    logic                              ready;
    logic [slmc_pkg::KIND_W-1:0]       kind;
    logic [slmc_pkg::VALUE_W-1:0]      value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);

endinterface

// File: rtl/slmc_out_if.sv
// ----------------------------------------------------------------------------
// slmc_out_if
// Result channel: merged union elements with membership tag.
// ----------------------------------------------------------------------------
interface slmc_out_if;

    logic                              valid;
    logic                              ready;
    logic [slmc_pkg::VALUE_W-1:0]      merged_value;
    logic [slmc_pkg::MEMB_W-1:0]       membership;
    logic                              last;
    logic                              exhausted;

    modport source (output valid, output merged_value, output membership,
                    output last, output exhausted, input ready);
    modport sink   (input valid, input merged_value, input membership,
                    input last, input exhausted, output ready);

endinterface

// File: rtl/slmc_ctrl.sv
// ----------------------------------------------------------------------------
// slmc_ctrl
// Controller: decodes accepted items and sequences the emit through its compare state.
// ----------------------------------------------------------------------------
module slmc_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic [slmc_pkg::KIND_W-1:0]     i_kind,
    input  slmc_pkg::t_dp_status            i_status,
    output logic                            o_in_ready,
    output slmc_pkg::t_dp_cmd               o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EMIT = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        slmc_pkg::KIND_LOAD_FIRST:  o_cmd.load_first  = 1'b1;
                        slmc_pkg::KIND_LOAD_SECOND: o_cmd.load_second = 1'b1;
                        slmc_pkg::KIND_CLEAR:       o_cmd.clear       = 1'b1;
                        slmc_pkg::KIND_EMIT:        n_state           = S_EMIT;
                        default:                    n_state           = S_IDLE;
                    endcase
                end
            end
            S_EMIT: begin
                // heads are in the read registers, wait for a free output slot
                if (!i_status.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // an accepted emit always moves on to the compare cycle
    a_emit_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_kind == slmc_pkg::KIND_EMIT) |=> (r_state == S_EMIT))
        else $error("emit item did not enter compare state");

endmodule

// File: rtl/slmc_dp.sv
// ----------------------------------------------------------------------------
// slmc_dp
// Datapath: two list memories, counts, merge positions, head compare and
// the output register.
// ----------------------------------------------------------------------------
module slmc_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  slmc_pkg::t_dp_cmd               i_cmd,
    input  logic [slmc_pkg::VALUE_W-1:0]    i_value,
    output slmc_pkg::t_dp_status            o_status,
    slmc_out_if.source                      o_out
);

    logic [slmc_pkg::ID_WIDTH-1:0] mem_first  [slmc_pkg::LIST_DEPTH];
    logic [slmc_pkg::ID_WIDTH-1:0] mem_second [slmc_pkg::LIST_DEPTH];

    logic [slmc_pkg::ID_WIDTH-1:0] r_head_first;
    logic [slmc_pkg::ID_WIDTH-1:0] r_head_second;

    logic [slmc_pkg::CNT_W-1:0]    r_cnt_first;
    logic [slmc_pkg::CNT_W-1:0]    r_cnt_second;
    logic [slmc_pkg::CNT_W-1:0]    r_pos_first;
    logic [slmc_pkg::CNT_W-1:0]    r_pos_second;
    logic [slmc_pkg::CNT_W-1:0]    n_pos_first;
    logic [slmc_pkg::CNT_W-1:0]    n_pos_second;

    logic                          r_out_valid;
    logic [slmc_pkg::VALUE_W-1:0]  r_out_value;
    logic [slmc_pkg::MEMB_W-1:0]   r_out_memb;
    logic                          r_out_last;
    logic                          r_out_exh;

    logic                          has_first;
    logic                          has_second;
    logic                          take_first;
    logic                          take_second;
    logic                          exhausted;
    logic                          is_last;
    logic [slmc_pkg::ID_WIDTH-1:0] emit_id;
    logic [slmc_pkg::MEMB_W-1:0]   emit_memb;

    logic [slmc_pkg::ID_WIDTH-1:0] load_id;

    assign load_id = i_value[slmc_pkg::ID_WIDTH-1:0];

    // list memories: append at the count, read the head every cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_first && r_cnt_first < slmc_pkg::LIST_FULL) begin
            mem_first[r_cnt_first[slmc_pkg::PTR_W-1:0]] <= load_id;
        end
        r_head_first <= mem_first[r_pos_first[slmc_pkg::PTR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_second && r_cnt_second < slmc_pkg::LIST_FULL) begin
            mem_second[r_cnt_second[slmc_pkg::PTR_W-1:0]] <= load_id;
        end
        r_head_second <= mem_second[r_pos_second[slmc_pkg::PTR_W-1:0]];
    end

    // head compare and position advance
    always_comb begin
        has_first   = (r_pos_first < r_cnt_first);
        has_second  = (r_pos_second < r_cnt_second);
        take_first  = has_first && (!has_second || r_head_first < r_head_second);
        take_second = !take_first && has_second
                      && (!has_first || r_head_second < r_head_first);
        exhausted   = !has_first && !has_second;

        n_pos_first  = r_pos_first;
        n_pos_second = r_pos_second;
        emit_id      = r_head_first;
        emit_memb    = slmc_pkg::MEMB_BOTH;
        if (take_first) begin
            emit_memb   = slmc_pkg::MEMB_FIRST;
            n_pos_first = r_pos_first + 1'b1;
        end else if (take_second) begin
            emit_id      = r_head_second;
            emit_memb    = slmc_pkg::MEMB_SECOND;
            n_pos_second = r_pos_second + 1'b1;
        end else if (!exhausted) begin
            // equal heads advance both lists
            n_pos_first  = r_pos_first + 1'b1;
            n_pos_second = r_pos_second + 1'b1;
        end
        is_last = (n_pos_first >= r_cnt_first) && (n_pos_second >= r_cnt_second);
    end

    // counts and positions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_cnt_first  <= '0;
            r_cnt_second <= '0;
            r_pos_first  <= '0;
            r_pos_second <= '0;
        end else begin
            if (i_cmd.load_first && r_cnt_first < slmc_pkg::LIST_FULL) begin
                r_cnt_first <= r_cnt_first + 1'b1;
            end
            if (i_cmd.load_second && r_cnt_second < slmc_pkg::LIST_FULL) begin
                r_cnt_second <= r_cnt_second + 1'b1;
            end
            if (i_cmd.emit) begin
                r_pos_first  <= n_pos_first;
                r_pos_second <= n_pos_second;
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (exhausted) begin
                r_out_value <= '0;
                r_out_memb  <= slmc_pkg::MEMB_FIRST;
                r_out_last  <= 1'b0;
                r_out_exh   <= 1'b1;
            end else begin
                r_out_value <= slmc_pkg::VALUE_W'(emit_id);
                r_out_memb  <= emit_memb;
                r_out_last  <= is_last;
                r_out_exh   <= 1'b0;
            end
        end
    end

    assign o_status.out_busy  = r_out_valid && !o_out.ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.merged_value = r_out_value;
    assign o_out.membership   = r_out_memb;
    assign o_out.last         = r_out_last;
    assign o_out.exhausted    = r_out_exh;

    // merge positions never pass the fill counts
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos_first <= r_cnt_first) && (r_pos_second <= r_cnt_second))
        else $error("merge position beyond list count");

    // fill counts stay within capacity
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_first <= slmc_pkg::LIST_FULL) && (r_cnt_second <= slmc_pkg::LIST_FULL))
        else $error("list count beyond capacity");

    // an exhausted result carries zero fields
    a_exh_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_exh) |->
            (r_out_value == '0 && r_out_memb == slmc_pkg::MEMB_FIRST && !r_out_last))
        else $error("exhausted result with non-zero fields");

    // an emit always presents a result next cycle
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_out_valid)
        else $error("emit did not produce a result");

endmodule

// File: rtl/sorted_list_merge_classify.sv
// ----------------------------------------------------------------------------
// sorted_list_merge_classify
// Merges two ascending ID lists into their union, tagging each element as
// first only, second only or both.
// ----------------------------------------------------------------------------
// Load and clear items take effect when accepted; a new item is accepted the
// next cycle. An emit item moves to the compare state: the list heads come out
// of the registered memory read, then they are compared and the result is
// registered once the output register is free. No item is accepted meanwhile.
// Reset clears counts, positions, controller state and output valid; the list
// memories are not cleared and need no clearing pass.
module sorted_list_merge_classify (
    input  logic         i_clk,
    input  logic         i_rst_n,
    slmc_in_if.sink      i_in,
    slmc_out_if.source   o_out
);

    slmc_pkg::t_dp_cmd    cmd;
    slmc_pkg::t_dp_status status;
    logic                 in_ready;

    assign i_in.ready = in_ready;

    // sequencing
    slmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_kind     (i_in.kind),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // storage, compare and output register
    slmc_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_value  (i_in.value),
        .o_status (status),
        .o_out    (o_out)
    );

endmodule
